// ----- src/rwgm_pkg.sv -----
package rwgm_pkg;

  localparam int QueueDepthDefault = 64;
  localparam int MaxGroupDefault   = 8;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_MATCH  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] STS_ADDED     = 3'd0;
  localparam logic [2:0] STS_FULL      = 3'd1;
  localparam logic [2:0] STS_REMOVED   = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_MEMBER    = 3'd4;
  localparam logic [2:0] STS_NO_MATCH  = 3'd5;
  localparam logic [2:0] STS_CLEARED   = 3'd6;

  localparam logic REG_MAX_DIFF   = 1'b0;
  localparam logic REG_GROUP_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] entry_id;
    logic [15:0] rating;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] member_id;
    logic [31:0] room_number;
    logic [6:0]  queue_count;
    logic        last;
  } out_t;

endpackage

// ----- src/rwgm_ram.sv -----
module rwgm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/rating_window_group_matcher.sv -----
// Add, clear and a short-queue match answer in the cycle after the request;
// remove reads the whole queue and shifts the entries after the match down.
// A match scans the queue until the group is full (or answers no match), compacts
// the queue, then emits one member per cycle, staying busy until the last member.
// Synchronous reset empties the queue, zeroes the room counter and loads
// max_rating_diff = 100, group_size = 2. The receiver cannot stall results.
module rating_window_group_matcher #(
  parameter int QUEUE_DEPTH = rwgm_pkg::QueueDepthDefault,
  parameter int MAX_GROUP   = rwgm_pkg::MaxGroupDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rwgm_pkg::in_t req,
  output logic          done,
  output rwgm_pkg::out_t result,
  input  logic          wr_en,
  input  logic          wr_index,
  input  logic [15:0]   wr_data
);
  import rwgm_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int OW = IW + 1;
  localparam int CW = $clog2(MAX_GROUP + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_REMOVE  = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]    state;
  logic [15:0]   max_rating_diff;
  logic [3:0]    group_size;
  logic [OW-1:0] occ;
  logic [31:0]   room_counter;

  // Scan bookkeeping: read pointer, and the index of the data arriving now.
  logic [OW-1:0] rd_idx;
  logic          rd_vld;
  logic [IW-1:0] dat_idx;
  logic [IW-1:0] wptr;
  logic          found;
  logic [31:0]   req_id;

  // Selected group members, filled in selection order.
  logic [CW-1:0] sel_n;
  logic [15:0]   sel_rat [MAX_GROUP];
  logic [IW-1:0] sel_pos [MAX_GROUP];
  logic [31:0]   sel_id  [MAX_GROUP];
  logic [CW-1:0] emit_cnt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [47:0]   ram_wdata;
  logic [47:0]   ram_rdata;
  logic [31:0]   dat_id;
  logic [15:0]   dat_rat;

  logic [CW-1:0] need;
  logic          issue;
  logic          fits;
  logic          is_sel;
  logic [6:0]    occ_out;
  logic [31:0]   occ_w;

  rwgm_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign dat_id  = ram_rdata[47:16];
  assign dat_rat = ram_rdata[15:0];
  assign busy    = (state != S_IDLE);

  // Clamp group_size to 1..MAX_GROUP.
  always_comb begin
    if (group_size == 4'd0) begin
      need = CW'(1);
    end else if (32'(group_size) > 32'(MAX_GROUP)) begin
      need = CW'(MAX_GROUP);
    end else begin
      need = CW'(group_size);
    end
  end

  // Issue the next read while entries remain; stop the scan once the group is full.
  always_comb begin
    issue = (32'(rd_idx) < 32'(occ));
    if (state == S_SCAN && sel_n >= need) begin
      issue = 1'b0;
    end
  end

  // Candidate must sit inside the window of every member chosen so far.
  always_comb begin
    logic [16:0] d;
    fits = 1'b1;
    for (int j = 0; j < MAX_GROUP; j++) begin
      d = (sel_rat[j] > dat_rat) ? {1'b0, sel_rat[j]} - {1'b0, dat_rat}
                                 : {1'b0, dat_rat} - {1'b0, sel_rat[j]};
      if (CW'(j) < sel_n && d > {1'b0, max_rating_diff}) begin
        fits = 1'b0;
      end
    end
  end

  always_comb begin
    is_sel = 1'b0;
    for (int j = 0; j < MAX_GROUP; j++) begin
      if (CW'(j) < sel_n && sel_pos[j] == dat_idx) begin
        is_sel = 1'b1;
      end
    end
  end

  // Single RAM write port: append on add, shift down on remove, compact on match.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = occ[IW-1:0];
    ram_wdata = {req.entry_id, req.rating};
    case (state)
      S_IDLE: begin
        ram_we = start && req.action == ACT_ADD && 32'(occ) < QUEUE_DEPTH;
      end
      S_REMOVE: begin
        ram_we    = rd_vld && found;
        ram_waddr = dat_idx - IW'(1);
        ram_wdata = ram_rdata;
      end
      S_COMPACT: begin
        ram_we    = rd_vld && !is_sel;
        ram_waddr = wptr;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign occ_w   = 32'(occ);
  assign occ_out = occ_w[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      max_rating_diff <= 16'd100;
      group_size      <= 4'd2;
      occ             <= '0;
      room_counter    <= '0;
      done            <= 1'b0;
      rd_vld          <= 1'b0;
      sel_n           <= '0;
    end else begin
      done <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          REG_MAX_DIFF:   max_rating_diff <= wr_data;
          REG_GROUP_SIZE: group_size      <= wr_data[3:0];
          default:        max_rating_diff <= max_rating_diff;
        endcase
      end

      // Advance the read stream of whichever scan is running.
      if (state == S_SCAN || state == S_REMOVE || state == S_COMPACT) begin
        rd_vld  <= issue;
        dat_idx <= rd_idx[IW-1:0];
        if (issue) begin
          rd_idx <= rd_idx + OW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            result.member_id   <= '0;
            result.room_number <= '0;
            result.last        <= 1'b1;
            rd_idx             <= '0;
            rd_vld             <= 1'b0;
            found              <= 1'b0;
            req_id             <= req.entry_id;
            sel_n              <= '0;
            case (req.action)
              ACT_ADD: begin
                done <= 1'b1;
                if (32'(occ) < QUEUE_DEPTH) begin
                  occ                <= occ + OW'(1);
                  result.status      <= STS_ADDED;
                  result.queue_count <= occ_out + 7'd1;
                end else begin
                  result.status      <= STS_FULL;
                  result.queue_count <= occ_out;
                end
              end
              ACT_REMOVE: state <= S_REMOVE;
              ACT_MATCH: begin
                if (32'(occ) < 32'(need)) begin
                  done               <= 1'b1;
                  result.status      <= STS_NO_MATCH;
                  result.queue_count <= occ_out;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_CLEAR: begin
                done               <= 1'b1;
                occ                <= '0;
                result.status      <= STS_CLEARED;
                result.queue_count <= 7'd0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_REMOVE: begin
          if (rd_vld && !found && dat_id == req_id) begin
            found <= 1'b1;
          end
          if (!rd_vld && !issue) begin
            done          <= 1'b1;
            state         <= S_IDLE;
            result.status <= found ? STS_REMOVED : STS_NOT_FOUND;
            if (found) begin
              occ                <= occ - OW'(1);
              result.queue_count <= occ_out - 7'd1;
            end else begin
              result.queue_count <= occ_out;
            end
          end
        end

        S_SCAN: begin
          // Take the candidate into the group; drop data read past a full group.
          if (rd_vld && sel_n < need && fits) begin
            for (int j = 0; j < MAX_GROUP; j++) begin
              if (CW'(j) == sel_n) begin
                sel_rat[j] <= dat_rat;
                sel_pos[j] <= dat_idx;
                sel_id[j]  <= dat_id;
              end
            end
            sel_n <= sel_n + CW'(1);
          end
          if (!rd_vld && !issue) begin
            if (sel_n >= need) begin
              state  <= S_COMPACT;
              rd_idx <= '0;
              wptr   <= '0;
            end else begin
              done               <= 1'b1;
              state              <= S_IDLE;
              result.status      <= STS_NO_MATCH;
              result.queue_count <= occ_out;
            end
          end
        end

        S_COMPACT: begin
          if (rd_vld && !is_sel) begin
            wptr <= wptr + IW'(1);
          end
          if (!rd_vld && !issue) begin
            occ      <= occ - OW'(sel_n);
            emit_cnt <= '0;
            state    <= S_EMIT;
          end
        end

        S_EMIT: begin
          // One member per cycle; shift the id line toward the output.
          done               <= 1'b1;
          result.status      <= STS_MEMBER;
          result.member_id   <= sel_id[0];
          result.room_number <= room_counter;
          result.queue_count <= occ_out;
          result.last        <= (emit_cnt == sel_n - CW'(1));
          for (int j = 0; j < MAX_GROUP - 1; j++) begin
            sel_id[j] <= sel_id[j+1];
          end
          emit_cnt <= emit_cnt + CW'(1);
          if (emit_cnt == sel_n - CW'(1)) begin
            room_counter <= room_counter + 32'd1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= QUEUE_DEPTH)
    else $error("occupancy above queue depth");

  a_emit_member: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |=> done && result.status == STS_MEMBER)
    else $error("emit cycle without member result");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> sel_n <= need)
    else $error("group grew past its size");

  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.action == ACT_ADD) |=> !busy && done)
    else $error("add did not answer in one cycle");
`endif
endmodule

// ----- test/rating_window_group_matcher_tb.sv -----
module rating_window_group_matcher_tb;
  import rwgm_pkg::*;

  localparam int Depth    = QueueDepthDefault;
  localparam int GroupMax = MaxGroupDefault;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  in_t   req;
  logic  done;
  out_t  result;
  logic  wr_en;
  logic  wr_index;
  logic [15:0] wr_data;

  rating_window_group_matcher i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Shadow of the block: waiting queue, room counter and both registers.
  logic [31:0] wait_ids[Depth];
  logic [15:0] wait_ratings[Depth];
  int          wait_count;
  logic [31:0] next_room;
  logic [15:0] rating_window;
  logic [3:0]  group_cfg;

  in_t  request_q[$];
  out_t expected_q[$];
  int   mismatches;
  int   accepted;
  int   sender_idle_pct;
  logic taken;

  // Used by the stimulus to pick ids that were added recently.
  logic [31:0] model_ids[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void post_expected(out_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic void post_request(in_t r);
    request_q = {request_q, r};
  endfunction

  function automatic out_t make_result(logic [2:0] sts, logic [31:0] id,
                                       logic [31:0] room, logic fin);
    out_t r;
    r.status      = sts;
    r.member_id   = id;
    r.room_number = room;
    r.queue_count = wait_count[6:0];
    r.last        = fin;
    return r;
  endfunction

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < wait_count; k++) begin
      wait_ids[k]     = wait_ids[k + 1];
      wait_ratings[k] = wait_ratings[k + 1];
    end
    wait_count--;
  endfunction

  function automatic logic within_window(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return d <= rating_window;
  endfunction

  // Work out the results of one request and update the shadow queue.
  function automatic void predict_request(in_t r);
    int need;
    int picked[$];
    logic [31:0] picked_ids[$];
    logic fits;
    int found;
    found = -1;
    case (r.action)
      ACT_ADD: begin
        if (wait_count >= Depth) begin
          post_expected(make_result(STS_FULL, 0, 0, 1'b1));
        end else begin
          wait_ids[wait_count]     = r.entry_id;
          wait_ratings[wait_count] = r.rating;
          wait_count++;
          post_expected(make_result(STS_ADDED, 0, 0, 1'b1));
        end
      end
      ACT_REMOVE: begin
        for (int k = 0; k < wait_count; k++) begin
          if (found < 0 && wait_ids[k] == r.entry_id) found = k;
        end
        if (found >= 0) begin
          drop_entry(found);
          post_expected(make_result(STS_REMOVED, 0, 0, 1'b1));
        end else begin
          post_expected(make_result(STS_NOT_FOUND, 0, 0, 1'b1));
        end
      end
      ACT_CLEAR: begin
        wait_count = 0;
        post_expected(make_result(STS_CLEARED, 0, 0, 1'b1));
      end
      default: begin
        need = (group_cfg == 0) ? 1 : (group_cfg > GroupMax) ? GroupMax : group_cfg;
        if (wait_count >= need) begin
          picked = {picked, 0};
          for (int k = 1; k < wait_count && picked.size() < need; k++) begin
            fits = 1'b1;
            foreach (picked[m]) begin
              if (!within_window(wait_ratings[picked[m]], wait_ratings[k])) fits = 1'b0;
            end
            if (fits) picked = {picked, k};
          end
        end
        if (wait_count < need || picked.size() < need) begin
          post_expected(make_result(STS_NO_MATCH, 0, 0, 1'b1));
        end else begin
          foreach (picked[m]) picked_ids = {picked_ids, wait_ids[picked[m]]};
          // Positions ascend, so drop from the back.
          for (int m = picked.size() - 1; m >= 0; m--) drop_entry(picked[m]);
          foreach (picked_ids[m]) begin
            post_expected(make_result(STS_MEMBER, picked_ids[m], next_room,
                                      m == picked_ids.size() - 1));
          end
          next_room = next_room + 1;
        end
      end
    endcase
  endfunction

  // Driver: present the oldest pending request, predict it on acceptance.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        // The request was taken at the last rising edge.
        predict_request(request_q.pop_front());
        accepted++;
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        req   <= request_q[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // taken marks a request accepted at this rising edge.
  always @(posedge clk) begin
    taken <= start && !busy && !rst;
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        if (result !== expected_q[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p got %p", expected_q[0], result);
          end
        end
        void'(expected_q.pop_front());
      end
    end
  end

  function automatic in_t mk(logic [1:0] act, logic [31:0] id, logic [15:0] rt);
    in_t r;
    r.action   = act;
    r.entry_id = id;
    r.rating   = rt;
    return r;
  endfunction

  // Hold until every queued request is taken and every result is back.
  task automatic drain();
    while (request_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    // Leave idle cycles before any register write.
    repeat (3 * Depth + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
    if (idx == REG_MAX_DIFF) rating_window = val;
    else group_cfg = val[3:0];
  endtask

  function automatic logic [31:0] fresh_id();
    logic [31:0] id;
    id = $urandom();
    model_ids = {model_ids, id};
    if (model_ids.size() > 200) void'(model_ids.pop_front());
    return id;
  endfunction

  // Mostly runs of adds around a center rating followed by matches.
  task automatic random_phase(int n, int win_lo, int win_hi);
    logic [15:0] center;
    int roll;
    center = $urandom();
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        post_request(mk(ACT_ADD, fresh_id(),
          16'(int'(center) + $urandom_range(win_hi) - win_lo)));
      end else if (roll < 75) begin
        post_request(mk(ACT_MATCH, $urandom(), $urandom()));
      end else if (roll < 90) begin
        post_request(mk(ACT_REMOVE,
          (model_ids.size() > 0 && roll < 85) ?
            model_ids[$urandom_range(model_ids.size() - 1)] : $urandom(), $urandom()));
      end else if (roll < 93) begin
        post_request(mk(ACT_CLEAR, $urandom(), $urandom()));
      end else begin
        post_request(mk(ACT_ADD, fresh_id(), $urandom()));
      end
      if ($urandom_range(99) < 5) center = $urandom();
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    req             = '0;
    wr_en           = 1'b0;
    wr_index        = 1'b0;
    wr_data         = '0;
    taken           = 1'b0;
    wait_count      = 0;
    next_room       = 0;
    rating_window   = 16'd100;
    group_cfg       = 4'd2;
    mismatches      = 0;
    accepted        = 0;
    sender_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every action, empty-queue cases.
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    post_request(mk(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF));
    post_request(mk(ACT_CLEAR, 32'd0, 16'd0));
    post_request(mk(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF));
    post_request(mk(ACT_ADD, 32'd0, 16'd0));
    post_request(mk(ACT_ADD, 32'h5555_5555, 16'hFF9B));
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    post_request(mk(ACT_ADD, 32'h5555_5555, 16'd50));
    post_request(mk(ACT_ADD, 32'hAAAA_AAAA, 16'd100));
    post_request(mk(ACT_REMOVE, 32'h5555_5555, 16'd0));
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    post_request(mk(ACT_CLEAR, 32'd0, 16'd0));
    post_request(mk(ACT_REMOVE, 32'd0, 16'd0));
    // Fill past the top to hit the full-queue drop.
    for (int k = 0; k <= Depth; k++) post_request(mk(ACT_ADD, k, 16'(k * 3)));
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    post_request(mk(ACT_CLEAR, 32'd0, 16'd0));
    drain();

    // Group size zero behaves as one; the extremes of both registers.
    write_reg(REG_GROUP_SIZE, 16'd0);
    write_reg(REG_MAX_DIFF, 16'd0);
    post_request(mk(ACT_ADD, 32'd7, 16'd9));
    post_request(mk(ACT_MATCH, 32'd0, 16'd0));
    random_phase(40, 0, 2);
    drain();

    write_reg(REG_GROUP_SIZE, 16'd15);
    write_reg(REG_MAX_DIFF, 16'hFFFF);
    sender_idle_pct = 71;
    random_phase(100, 30000, 60000);
    drain();

    write_reg(REG_GROUP_SIZE, 16'd3);
    write_reg(REG_MAX_DIFF, 16'd20);
    sender_idle_pct = 13;
    random_phase(100, 15, 30);
    drain();

    write_reg(REG_GROUP_SIZE, 16'd8);
    write_reg(REG_MAX_DIFF, 16'd500);
    sender_idle_pct = 0;
    random_phase(100, 200, 400);
    drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Generous watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rwgm_pkg.sv
src/rwgm_ram.sv
src/rating_window_group_matcher.sv
test/rating_window_group_matcher_tb.sv
